### sv/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### sv/pbm_pkg.sv
// Types, constants and helpers of the palette builder and mapper.
`default_nettype none
package pbm_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
   localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
   localparam int CHAN_W          = 8;
   localparam int RGB_W           = 3 * CHAN_W;
   localparam int SEL_W           = 8;
   localparam int OP_W            = 2;

   localparam int REQ_BITS    = RGB_W + SEL_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 2 * CNT_W + 2 + RGB_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 2'd0,
      OP_COLLECT = 2'd1,
      OP_MAP     = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_ALPHA    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_MODE = 1'b1;

   localparam logic [RGB_W-1:0] RGB_BLACK   = 24'h000000;
   localparam logic [RGB_W-1:0] RGB_MAGENTA = 24'hFF00FF;
   localparam logic [RGB_W-1:0] RGB_GREEN   = 24'h00FF00;
   localparam logic [RGB_W-1:0] RGB_RED     = 24'hFF0000;
   localparam logic [RGB_W-1:0] RGB_BLUE    = 24'h0000FF;
   localparam logic [RGB_W-1:0] RGB_YELLOW  = 24'hFFFF00;
   localparam logic [RGB_W-1:0] RGB_CYAN    = 24'h00FFFF;

   function automatic logic is_key_color(input logic [RGB_W-1:0] rgb);
      return (rgb == RGB_GREEN) || (rgb == RGB_RED) || (rgb == RGB_BLUE) ||
             (rgb == RGB_YELLOW) || (rgb == RGB_CYAN);
   endfunction

endpackage
`default_nettype wire

### sv/palette_builder_and_mapper.sv
// Palette builder and mapper: top level with control FSM and palette store.
// Clear and read go without a scan, and so does a collect on a full table.
// Collect and map scan the palette RAM one entry per cycle and stop at the first match.
// One item is in work at a time; the result register frees the input side.
// Synchronous reset clears control and the per-entry valid bits; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module palette_builder_and_mapper (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // red, green, blue, entry_select
   input  wire logic [pbm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // op
   input  wire logic [pbm_pkg::OP_W-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // color_index, added, table_full, color_count, entry_red, entry_green,
   // entry_blue, zero pad
   output logic      [pbm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic                             csr_data
);
   import pbm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RDISSUE,
      ST_FINISH
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(PALETTE_ENTRIES);

   state_type state_ff, state_in;

   op_type             op_ff;
   logic [RGB_W-1:0]   rgb_ff;
   logic [SEL_W-1:0]   sel_ff;

   logic [ADDR_W-1:0]  scan_addr_ff, scan_addr_in;
   logic               issue_done_ff, issue_done_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic               hit_ff, hit_in;
   logic [ADDR_W-1:0]  hit_idx_ff, hit_idx_in;

   logic [PALETTE_ENTRIES-1:0] valid_ff, valid_in;
   logic               valid_q_ff;
   logic [CNT_W-1:0]   next_slot_ff, next_slot_in;
   logic               black_seen_ff, black_seen_in;
   logic               full_ff, full_in;
   logic               no_alpha_ff, no_alpha_in;
   logic               sprite_ff, sprite_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               req_fire;
   logic               rsp_free;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [RGB_W-1:0]   rd_data;
   logic [RGB_W-1:0]   rd_color;
   logic               scan_match;
   logic               scan_last;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [RGB_W-1:0]   wr_data;
   logic [ADDR_W-1:0]  sel_addr;
   logic               sel_in_range;
   logic [CNT_W-1:0]   slot_plus;

   logic [CNT_W-1:0]   res_index;
   logic               res_added;
   logic [RGB_W-1:0]   res_entry;
   logic               do_append;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sel_addr     = ADDR_W'(sel_ff);
   assign sel_in_range = 32'(sel_ff) < 32'(PALETTE_ENTRIES);

   assign rd_en    = ((state_ff == ST_SCAN) && !issue_done_ff) || (state_ff == ST_RDISSUE);
   assign rd_addr  = (state_ff == ST_RDISSUE) ? sel_addr : scan_addr_ff;
   // an entry never written since clear reads as zero
   assign rd_color = valid_q_ff ? rd_data : '0;

   assign scan_match = pend_ff && (rd_color == rgb_ff);
   assign scan_last  = pend_ff && (pend_addr_ff == LAST_ADDR);
   assign slot_plus  = next_slot_ff + 1'b1;

   pbm_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      scan_addr_in  = scan_addr_ff;
      issue_done_in = issue_done_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      valid_in      = valid_ff;
      next_slot_in  = next_slot_ff;
      black_seen_in = black_seen_ff;
      full_in       = full_ff;
      no_alpha_in   = no_alpha_ff;
      sprite_in     = sprite_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      res_index     = '0;
      res_added     = 1'b0;
      res_entry     = '0;
      do_append     = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NO_ALPHA:    no_alpha_in = csr_data;
            CSR_SPRITE_MODE: sprite_in   = csr_data;
            default:         ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               scan_addr_in  = '0;
               issue_done_in = 1'b0;
               pend_in       = 1'b0;
               hit_in        = 1'b0;
               case (op_type'(req_tuser))
                  OP_CLEAR:   state_in = ST_FINISH;
                  OP_COLLECT: state_in = full_ff ? ST_FINISH : ST_SCAN;
                  OP_MAP:     state_in = ST_SCAN;
                  default:    state_in = ST_RDISSUE;
               endcase
            end
         end
         ST_SCAN: begin
            pend_in      = rd_en;
            pend_addr_in = scan_addr_ff;
            if (rd_en) begin
               if (scan_addr_ff == LAST_ADDR) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            if (scan_match) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_addr_ff;
               pend_in    = 1'b0;
               state_in   = ST_FINISH;
            end else if (scan_last) begin
               pend_in  = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_RDISSUE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold here until the result register can take the beat
            if (rsp_free) begin
               state_in = ST_IDLE;
               case (op_ff)
                  OP_CLEAR: begin
                     valid_in      = '0;
                     valid_in[0]   = !sprite_ff;
                     wr_en         = !sprite_ff;
                     wr_addr       = '0;
                     wr_data       = RGB_MAGENTA;
                     next_slot_in  = no_alpha_ff ? '0 : CNT_W'(1);
                     black_seen_in = 1'b0;
                     full_in       = 1'b0;
                  end
                  OP_COLLECT: begin
                     if (!full_ff) begin
                        if (!hit_ff) begin
                           if (sprite_ff && !no_alpha_ff && (rgb_ff == RGB_MAGENTA)) begin
                              wr_en       = 1'b1;
                              wr_addr     = '0;
                              wr_data     = rgb_ff;
                              valid_in[0] = 1'b1;
                           end else if (!(sprite_ff && is_key_color(rgb_ff))) begin
                              do_append = 1'b1;
                           end
                        end else if (!black_seen_ff && (rgb_ff == RGB_BLACK)) begin
                           black_seen_in = 1'b1;
                           do_append     = 1'b1;
                        end
                     end
                     if (do_append) begin
                        res_added = 1'b1;
                        if (next_slot_ff < FULL_CNT) begin
                           wr_en             = 1'b1;
                           wr_addr           = ADDR_W'(next_slot_ff);
                           wr_data           = rgb_ff;
                           valid_in[wr_addr] = 1'b1;
                        end
                        if (slot_plus >= FULL_CNT) begin
                           next_slot_in = FULL_CNT;
                           full_in      = 1'b1;
                        end else begin
                           next_slot_in = slot_plus;
                        end
                     end
                  end
                  OP_MAP: begin
                     res_index = hit_ff ? CNT_W'(hit_idx_ff) : FULL_CNT;
                  end
                  default: begin
                     res_entry = sel_in_range ? rd_color : '0;
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({res_entry[CHAN_W-1:0],
                                            res_entry[2*CHAN_W-1:CHAN_W],
                                            res_entry[RGB_W-1:2*CHAN_W],
                                            next_slot_in, full_in, res_added, res_index});
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_addr_ff  <= '0;
         issue_done_ff <= 1'b0;
         pend_ff       <= 1'b0;
         pend_addr_ff  <= '0;
         hit_ff        <= 1'b0;
         hit_idx_ff    <= '0;
         valid_ff      <= '0;
         next_slot_ff  <= '0;
         black_seen_ff <= 1'b0;
         full_ff       <= 1'b0;
         no_alpha_ff   <= 1'b0;
         sprite_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_addr_ff  <= scan_addr_in;
         issue_done_ff <= issue_done_in;
         pend_ff       <= pend_in;
         pend_addr_ff  <= pend_addr_in;
         hit_ff        <= hit_in;
         hit_idx_ff    <= hit_idx_in;
         valid_ff      <= valid_in;
         next_slot_ff  <= next_slot_in;
         black_seen_ff <= black_seen_in;
         full_ff       <= full_in;
         no_alpha_ff   <= no_alpha_in;
         sprite_ff     <= sprite_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= op_type'(req_tuser);
         rgb_ff <= {req_tdata[CHAN_W-1:0], req_tdata[2*CHAN_W-1:CHAN_W],
                    req_tdata[RGB_W-1:2*CHAN_W]};
         sel_ff <= req_tdata[RGB_W+SEL_W-1:RGB_W];
      end
      if (rd_en) begin
         valid_q_ff <= valid_ff[rd_addr];
      end
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_IMPLY(a_slot_range, clock, reset, 1'b1, next_slot_ff <= FULL_CNT)
   `ASSERT_IMPLY(a_full_count, clock, reset, full_ff, next_slot_ff == FULL_CNT)
   `ASSERT_IMPLY(a_write_at_finish, clock, reset, wr_en, (state_ff == ST_FINISH) && rsp_free)
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != ST_IDLE)

endmodule
`default_nettype wire

### sv/pbm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data between reads
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
